// File: rtl/utf8v_pkg.sv
// Package for the UTF-8 stream validator: request types, byte range limits,
// sequence state and the lead/trailing byte helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

  localparam int unsigned CountBitsDefault = 32;
  localparam int unsigned TotalBits        = 32;

  localparam logic [7:0] TrailLo    = 8'h80;
  localparam logic [7:0] TrailHi    = 8'hBF;
  localparam logic [7:0] LeadMinOk  = 8'hC2;
  localparam logic [7:0] LeadMaxOk  = 8'hF4;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] SecE0Lo    = 8'hA0;
  localparam logic [7:0] SecEDHi    = 8'h9F;
  localparam logic [7:0] SecF0Lo    = 8'h90;
  localparam logic [7:0] SecF4Hi    = 8'h8F;

  localparam logic [2:0] MaxLegalExtra = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic                 char_done;
    logic                 char_legal;
    logic [2:0]           char_length;
    logic [TotalBits-1:0] char_total;
    logic                 truncated;
  } out_req_t;

  typedef struct packed {
    logic [7:0] lead_value;
    logic [2:0] bytes_left;
    logic [2:0] seq_length;
    logic       legal_so_far;
  } seq_state_t;

  localparam seq_state_t SeqReset = '{
    lead_value:   8'h00,
    bytes_left:   3'd0,
    seq_length:   3'd0,
    legal_so_far: 1'b1
  };

  function automatic logic [2:0] extra_bytes(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hC0)      n = 3'd0;
    else if (b < 8'hE0) n = 3'd1;
    else if (b < 8'hF0) n = 3'd2;
    else if (b < 8'hF8) n = 3'd3;
    else if (b < 8'hFC) n = 3'd4;
    else                n = 3'd5;
    return n;
  endfunction

  function automatic logic in_range(input logic [7:0] b, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    case (lead)
      LeadE0:  ok = in_range(b, SecE0Lo, TrailHi);
      LeadED:  ok = in_range(b, TrailLo, SecEDHi);
      LeadF0:  ok = in_range(b, SecF0Lo, TrailHi);
      LeadF4:  ok = in_range(b, TrailLo, SecF4Hi);
      default: ok = in_range(b, TrailLo, TrailHi);
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utf8v_step.sv
// Per-byte decode step: next sequence state and result fields for one byte.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8v_step (
  input  utf8v_pkg::seq_state_t state_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_text_i,
  output utf8v_pkg::seq_state_t state_o,
  output logic                  done_o,
  output logic                  legal_o,
  output logic [2:0]            length_o,
  output logic                  truncated_o
);
  import utf8v_pkg::*;

  logic [2:0] extra;
  logic       trail_ok;
  logic       lead_bad;
  seq_state_t upd;

  assign extra    = extra_bytes(data_byte_i);
  assign lead_bad = in_range(data_byte_i, TrailLo, LeadMinOk - 8'd1) ||
                    (data_byte_i > LeadMaxOk) || (extra > MaxLegalExtra);
  assign trail_ok = (state_i.bytes_left == state_i.seq_length - 3'd1) ?
                    second_ok(state_i.lead_value, data_byte_i) :
                    in_range(data_byte_i, TrailLo, TrailHi);

  always_comb begin
    upd = state_i;
    if (state_i.bytes_left == 3'd0) begin
      upd.lead_value   = data_byte_i;
      upd.seq_length   = extra + 3'd1;
      upd.legal_so_far = ~lead_bad;
      upd.bytes_left   = extra;
    end else begin
      upd.legal_so_far = state_i.legal_so_far & trail_ok;
      upd.bytes_left   = state_i.bytes_left - 3'd1;
    end
  end

  always_comb begin
    done_o      = 1'b0;
    legal_o     = 1'b0;
    length_o    = 3'd0;
    truncated_o = 1'b0;
    if (upd.bytes_left == 3'd0) begin
      done_o   = 1'b1;
      legal_o  = upd.legal_so_far;
      length_o = upd.seq_length;
    end else if (end_of_text_i) begin
      done_o      = 1'b1;
      length_o    = upd.seq_length;
      truncated_o = 1'b1;
    end
  end

  assign state_o = end_of_text_i ? SeqReset : upd;

endmodule

`default_nettype wire

// File: rtl/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator: sequence state, character counter
// and result register. Depends on utf8v_pkg and utf8v_step.
`timescale 1ns / 1ps
`default_nettype none

// One request byte in, one result out, at one byte per clock. Each accepted byte
// is decoded in the same cycle against the held sequence state and its result is
// loaded into a single output register, so a result appears in the cycle after its
// byte and a new byte is taken every cycle unless the output register is full and
// stalled. The character count is COUNT_BITS wide, saturates, and is reported as
// its low 32 bits; the byte flagged end_of_text resets sequence state and count.
module utf8_stream_validator #(
  parameter int unsigned COUNT_BITS = utf8v_pkg::CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  utf8v_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output utf8v_pkg::out_req_t out_req_o
);
  import utf8v_pkg::*;

  localparam int unsigned ExtBits = (COUNT_BITS > TotalBits) ? COUNT_BITS : TotalBits;

  seq_state_t            state_q, state_d;
  logic [COUNT_BITS-1:0] count_q, count_d, count_base;
  logic                  out_valid_q;
  out_req_t              out_req_q, out_req_d;
  logic                  accept;
  logic                  done;
  logic                  legal;
  logic [2:0]            length;
  logic                  trunc;
  logic [ExtBits-1:0]    count_ext;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  utf8v_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_req_i.data_byte),
    .end_of_text_i (in_req_i.end_of_text),
    .state_o       (state_d),
    .done_o        (done),
    .legal_o       (legal),
    .length_o      (length),
    .truncated_o   (trunc)
  );

  assign count_base = (done && (count_q != {COUNT_BITS{1'b1}})) ?
                      count_q + {{(COUNT_BITS-1){1'b0}}, 1'b1} : count_q;
  assign count_d    = in_req_i.end_of_text ? '0 : count_base;
  assign count_ext  = ExtBits'(count_base);

  always_comb begin
    out_req_d.char_done   = done;
    out_req_d.char_legal  = legal;
    out_req_d.char_length = length;
    out_req_d.char_total  = count_ext[TotalBits-1:0];
    out_req_d.truncated   = trunc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeqReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
        count_q <= count_d;
      end
      if (!in_stall_o) begin
        out_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_req_q <= out_req_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire

// File: rtl/utf8v_checker.sv
// Port-level checks for the UTF-8 stream validator, attached by bind.
// Depends on utf8v_pkg and utf8_stream_validator.
`timescale 1ns / 1ps
`default_nettype none

module utf8v_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input utf8v_pkg::in_req_t  in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input utf8v_pkg::out_req_t out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result request changed");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.char_done |->
      out_req_o.char_length == 3'd0 && !out_req_o.char_legal && !out_req_o.truncated)
    else $error("fields set without a completed character");

  a_trunc_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.truncated |-> out_req_o.char_done && !out_req_o.char_legal)
    else $error("truncated character reported legal or not done");

  a_done_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.char_done |->
      out_req_o.char_length != 3'd0 && out_req_o.char_length != 3'd7 &&
      (!out_req_o.char_legal || out_req_o.char_length == 3'd1 ||
       out_req_o.char_length == 3'd2 || out_req_o.char_length == 3'd3 ||
       out_req_o.char_length == 3'd4))
    else $error("bad character length");

  a_eot_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.end_of_text |=>
      out_valid_o && out_req_o.char_done)
    else $error("end of text request did not close a character");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (.*);

`default_nettype wire
